// ===== hdl/arp_pkg.sv =====
// Shared constants for the arpeggiator note sequencer: command, event,
// style and register codes plus default sizes. No dependencies.
`timescale 1ns / 1ps

package arp_pkg;

	localparam int MAX_NOTES_DEF  = 16;
	localparam int PITCH_BITS_DEF = 16;

	// stream widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	// input item command codes (s_tuser)
	localparam logic [2:0] CMD_NOTE_ON    = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF   = 3'd1;
	localparam logic [2:0] CMD_ALL_OFF    = 3'd2;
	localparam logic [2:0] CMD_STEP_BEGIN = 3'd3;
	localparam logic [2:0] CMD_STEP_END   = 3'd4;

	// emitted event codes (m_tuser)
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_ON   = 2'd1;
	localparam logic [1:0] EV_OFF  = 2'd2;

	// step order
	localparam logic [1:0] STYLE_UP     = 2'd0;
	localparam logic [1:0] STYLE_DOWN   = 2'd1;
	localparam logic [1:0] STYLE_RANDOM = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_STYLE  = 2'd0;
	localparam logic [1:0] REG_OUT_EN = 2'd1;

endpackage

// ===== hdl/arpeggiator_note_sequencer.sv =====
// Arpeggiator note sequencer: sorted held-note set in a synchronous RAM,
// step position logic and a shared serial modulo unit. Depends on arp_pkg.
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    tuser: cmd; tdata: pitch, random_value
// m_*       out  m_tvalid / m_tready    tuser: event_res; tdata: result fields
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// note_on / note_off: one linear pass over the RAM.
// step_begin: restoring modulo, one step per dividend bit, then a RAM read.
// all_off, step_end and unused commands: no scan and no modulo.
// One item at a time; a finished result sits in the output register, so the next
// item is accepted while it waits. Reset clears control state only; RAM entries are
// never read before being written.
`timescale 1ns / 1ps

module arpeggiator_note_sequencer
	import arp_pkg::*;
#(
	parameter int MAX_NOTES  = MAX_NOTES_DEF,
	parameter int PITCH_BITS = PITCH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] pitch, [31:16] random_value
	input  logic [2:0]          s_tuser,   // [2:0] cmd
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [15:0] event_pitch, [16] playing,
	                                       // [21:17] note_count, [22] pitch_was_held,
	                                       // [23] overflow
	output logic [1:0]          m_tuser,   // [1:0] event_res
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [1:0]          cfg_data
);

	localparam int IW  = $clog2(MAX_NOTES);
	localparam int CW  = $clog2(MAX_NOTES + 1);
	localparam int DVW = (CW + 1 > 16) ? CW + 1 : 16;
	localparam int BCW = $clog2(DVW + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_MOD, ST_RD, ST_DATA, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_SEEK, PH_SHIFT, PH_DONE
	} phase_t;

	function automatic logic [15:0] to16(input logic signed [PITCH_BITS-1:0] p);
		logic signed [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

	state_t                        state_q;
	phase_t                        ph_q, ph_n;
	logic [2:0]                    cmd_q;
	logic signed [PITCH_BITS-1:0]  pitch_q, carry_q, carry_n, snd_q;
	logic [CW-1:0]                 cnt_q, cnt_n, rd_idx_q;
	logic [IW-1:0]                 pos_q, idx_s1, rem_q, rem_n;
	logic                          pos_vld_q, snding_q, v_s1;
	logic [1:0]                    style_q;
	logic                          oen_q;
	logic [DVW-1:0]                dvd_q, dvd_init;
	logic [BCW-1:0]                bc_q;
	logic [1:0]                    res_ev_q;
	logic [15:0]                   res_pitch_q;
	logic                          res_held_q, res_ovf_q, held_n, ovf_n, stop_n;
	logic                          m_valid_q;
	logic [M_DATA_W-1:0]           m_data_q;
	logic [1:0]                    m_user_q;

	// held pitch RAM
	logic [PITCH_BITS-1:0]         mem [MAX_NOTES];
	logic [PITCH_BITS-1:0]         rdata_q;
	logic                          rd_en, we;
	logic [IW-1:0]                 rd_addr, wa;
	logic [PITCH_BITS-1:0]         wd;

	logic signed [31:0]            in_ext;
	logic signed [PITCH_BITS-1:0]  in_pitch, entry;
	logic                          full, scan_issue, proc, scan_end, off_now;
	logic [IW:0]                   trial, ncmp;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_user_q;

	assign in_ext   = 32'(signed'(s_tdata[15:0]));
	assign in_pitch = in_ext[PITCH_BITS-1:0];
	assign entry    = signed'(rdata_q);
	assign full     = (cnt_q == CW'(MAX_NOTES));

	// step_end that ends a sounding note with output enabled
	assign off_now  = (s_tuser == CMD_STEP_END) && snding_q && oen_q;

	// scan pipeline: read ahead one entry, write behind
	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q != cnt_q) && (ph_q != PH_DONE);
	assign proc       = (state_q == ST_SCAN) && v_s1 && (ph_q != PH_DONE);
	assign scan_end   = (state_q == ST_SCAN) && !v_s1 &&
	                    ((rd_idx_q == cnt_q) || (ph_q == PH_DONE));

	assign rd_en   = scan_issue || (state_q == ST_RD);
	assign rd_addr = (state_q == ST_RD) ? rem_q : rd_idx_q[IW-1:0];

	always_comb begin
		we      = 1'b0;
		wa      = idx_s1;
		wd      = carry_q;
		ph_n    = ph_q;
		carry_n = carry_q;
		held_n  = res_held_q;
		ovf_n   = res_ovf_q;
		cnt_n   = cnt_q;
		stop_n  = 1'b0;
		if (proc) begin
			if (cmd_q == CMD_NOTE_ON) begin
				if (ph_q == PH_SEEK) begin
					if (entry == pitch_q) begin
						held_n = 1'b1;
						ph_n   = PH_DONE;
					end else if (entry > pitch_q) begin
						if (full) begin
							ovf_n = 1'b1;
							ph_n  = PH_DONE;
						end else begin
							we      = 1'b1;
							wd      = pitch_q;
							carry_n = entry;
							ph_n    = PH_SHIFT;
						end
					end
				end else begin
					we      = 1'b1;
					wd      = carry_q;
					carry_n = entry;
				end
			end else begin
				if (ph_q == PH_SEEK) begin
					if (entry == pitch_q) begin
						held_n = 1'b1;
						ph_n   = PH_SHIFT;
					end else if (entry > pitch_q) begin
						ph_n = PH_DONE;
					end
				end else begin
					// move each later entry down over the removed one
					we = 1'b1;
					wa = idx_s1 - IW'(1);
					wd = entry;
				end
			end
		end
		if (scan_end) begin
			if (cmd_q == CMD_NOTE_ON) begin
				if (ph_q == PH_SEEK && full) begin
					ovf_n = 1'b1;
				end else if (ph_q != PH_DONE) begin
					// append new pitch or the last shifted-out entry
					we    = 1'b1;
					wa    = cnt_q[IW-1:0];
					wd    = (ph_q == PH_SEEK) ? pitch_q : carry_q;
					cnt_n = cnt_q + CW'(1);
				end
			end else if (ph_q == PH_SHIFT) begin
				cnt_n  = cnt_q - CW'(1);
				stop_n = (cnt_n == '0);
			end
		end
	end

	// modulo dividend for the next step position
	always_comb begin
		unique case (style_q)
			STYLE_DOWN:   dvd_init = pos_vld_q ? DVW'(pos_q) + DVW'(cnt_q) - DVW'(1)
			                                   : DVW'(cnt_q) - DVW'(1);
			STYLE_RANDOM: dvd_init = DVW'(s_tdata[31:16]);
			default:      dvd_init = pos_vld_q ? DVW'(pos_q) + DVW'(1) : '0;
		endcase
	end

	// one restoring step per cycle
	assign trial = {rem_q, dvd_q[DVW-1]};
	assign ncmp  = (IW+1)'(cnt_q);
	assign rem_n = (trial >= ncmp) ? IW'(trial - ncmp) : IW'(trial);

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ph_q      <= PH_SEEK;
			cnt_q     <= '0;
			pos_q     <= '0;
			pos_vld_q <= 1'b0;
			snd_q     <= '0;
			snding_q  <= 1'b0;
			style_q   <= STYLE_UP;
			oen_q     <= 1'b1;
			v_s1      <= 1'b0;
			rd_idx_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_STYLE:  style_q <= cfg_data;
					REG_OUT_EN: oen_q   <= cfg_data[0];
					default:    ;
				endcase
			end

			if (state_q == ST_FINISH && (!m_valid_q || m_tready))
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;

			v_s1 <= scan_issue;
			if (scan_issue) begin
				idx_s1   <= rd_idx_q[IW-1:0];
				rd_idx_q <= rd_idx_q + CW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q       <= s_tuser;
						pitch_q     <= in_pitch;
						res_ev_q    <= off_now ? EV_OFF : EV_NONE;
						res_pitch_q <= off_now ? to16(snd_q) : 16'd0;
						res_held_q  <= 1'b0;
						res_ovf_q   <= 1'b0;
						ph_q        <= PH_SEEK;
						rd_idx_q    <= '0;
						unique case (s_tuser)
							CMD_NOTE_ON, CMD_NOTE_OFF: begin
								state_q <= ST_SCAN;
							end
							CMD_ALL_OFF: begin
								if (cnt_q != '0) begin
									cnt_q     <= '0;
									pos_q     <= '0;
									pos_vld_q <= 1'b0;
								end
								state_q <= ST_FINISH;
							end
							CMD_STEP_BEGIN: begin
								if (cnt_q != '0) begin
									dvd_q   <= dvd_init;
									rem_q   <= '0;
									bc_q    <= BCW'(DVW - 1);
									state_q <= ST_MOD;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							CMD_STEP_END: begin
								if (snding_q)
									snding_q <= 1'b0;
								state_q <= ST_FINISH;
							end
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_SCAN: begin
					ph_q       <= ph_n;
					carry_q    <= carry_n;
					res_held_q <= held_n;
					res_ovf_q  <= ovf_n;
					cnt_q      <= cnt_n;
					if (stop_n) begin
						pos_q     <= '0;
						pos_vld_q <= 1'b0;
					end
					if (scan_end)
						state_q <= ST_FINISH;
				end
				ST_MOD: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					bc_q  <= bc_q - BCW'(1);
					if (bc_q == '0)
						state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					pos_q     <= rem_q;
					pos_vld_q <= 1'b1;
					snd_q     <= entry;
					snding_q  <= 1'b1;
					if (oen_q) begin
						res_ev_q    <= EV_ON;
						res_pitch_q <= to16(entry);
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!m_valid_q || m_tready) begin
						m_data_q  <= {res_ovf_q, res_held_q, 5'(cnt_q), (cnt_q != '0),
						              res_pitch_q};
						m_user_q  <= res_ev_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/arp_checker.sv =====
// Port-level checks for the arpeggiator note sequencer, bound to the top level.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_checker
	import arp_pkg::*;
#(
	parameter int MAX_NOTES = MAX_NOTES_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	localparam bit CNT_FITS = (MAX_NOTES < 32);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_quiet_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_NONE) |-> (m_tdata[15:0] == 16'd0))
		else $error("event pitch nonzero without an event");

	a_playing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !CNT_FITS || (m_tdata[16] == (m_tdata[21:17] != 5'd0)))
		else $error("playing flag disagrees with note count");

	a_ovf_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> !m_tdata[22] && CNT_FITS &&
		(m_tdata[21:17] == 5'(MAX_NOTES)) || !CNT_FITS)
		else $error("overflow on a held pitch or a set that is not full");

endmodule

bind arpeggiator_note_sequencer arp_checker #(.MAX_NOTES(MAX_NOTES)) u_arp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/testbench.sv =====
// Self-checking bench for arpeggiator_note_sequencer: a queue-fed stream driver,
// a checking monitor with its own note-set predictor, and register writes between phases.
// Depends on arp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
	import arp_pkg::*;

	localparam int NOTE_SLOTS = MAX_NOTES_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 9;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [15:0] pitch;
		logic [15:0]        rnd;
	} note_cmd_t;

	typedef struct packed {
		logic [1:0]         ev;
		logic signed [15:0] ev_pitch;
		logic               playing;
		logic [4:0]         count;
		logic               was_held;
		logic               ovf;
	} note_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [1:0] cfg_data = '0;

	arpeggiator_note_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// pending note commands and expected results
	note_cmd_t    pending_cmds [$];
	note_result_t expected_results [$];

	// predictor state
	logic signed [15:0] held_notes [NOTE_SLOTS];
	int                 held_n = 0;
	int                 step_pos = 0;
	bit                 pos_valid = 1'b0;
	logic signed [15:0] cur_pitch = '0;
	bit                 sounding = 1'b0;
	logic [1:0]         arp_style = STYLE_UP;
	bit                 out_en = 1'b1;

	// stimulus control
	int queued = 0;
	int idle_pct = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// monitor bookkeeping
	bit in_taken = 1'b0;
	int items_in = 0;
	int n_results = 0;
	int n_on_ev = 0;
	int n_off_ev = 0;
	int n_dropped = 0;
	int n_reg_writes = 0;
	int stall_cycles = 0;
	int errors = 0;
	note_result_t want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (errors < 40)
			$display("MISMATCH at result %0d: %s", n_results, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %h expected %h", name, got, exp_val));
	endtask

	// advances the held-note model by one command and returns its result
	function automatic note_result_t apply_note_cmd(input logic [2:0] cmd,
			input logic signed [15:0] pitch, input logic [15:0] rnd);
		note_result_t r;
		int pos;
		int i;
		r = '0;
		if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
			pos = 0;
			while (pos < held_n && held_notes[pos] < pitch)
				pos++;
			if (pos < held_n && held_notes[pos] == pitch)
				r.was_held = 1'b1;
			if (cmd == CMD_NOTE_ON) begin
				if (!r.was_held) begin
					if (held_n >= NOTE_SLOTS) begin
						r.ovf = 1'b1;
						n_dropped++;
					end else begin
						for (i = held_n; i > pos; i--)
							held_notes[i] = held_notes[i-1];
						held_notes[pos] = pitch;
						held_n++;
					end
				end
			end else if (r.was_held) begin
				for (i = pos; i + 1 < held_n; i++)
					held_notes[i] = held_notes[i+1];
				held_n--;
				if (held_n == 0) begin
					step_pos = 0;
					pos_valid = 1'b0;
				end
			end
		end else if (cmd == CMD_ALL_OFF) begin
			held_n = 0;
			step_pos = 0;
			pos_valid = 1'b0;
		end else if (cmd == CMD_STEP_BEGIN) begin
			if (held_n != 0) begin
				// a stale position past the end wraps through the modulo
				case (arp_style)
					STYLE_DOWN: step_pos = pos_valid ? (step_pos + held_n - 1) % held_n
						: held_n - 1;
					STYLE_RANDOM: step_pos = int'(rnd) % held_n;
					default: step_pos = pos_valid ? (step_pos + 1) % held_n : 0;
				endcase
				pos_valid = 1'b1;
				cur_pitch = held_notes[step_pos];
				sounding = 1'b1;
				if (out_en) begin
					r.ev = EV_ON;
					r.ev_pitch = cur_pitch;
				end
			end
		end else if (cmd == CMD_STEP_END) begin
			// note-off goes out even if the set was emptied meanwhile
			if (sounding) begin
				sounding = 1'b0;
				if (out_en) begin
					r.ev = EV_OFF;
					r.ev_pitch = cur_pitch;
				end
			end
		end
		r.playing = (held_n != 0);
		r.count = held_n[4:0];
		return r;
	endfunction

	function automatic void queue_cmd(input logic [2:0] cmd, input logic [15:0] pitch,
			input logic [15:0] rnd);
		note_cmd_t c;
		c.cmd = cmd;
		c.pitch = pitch;
		c.rnd = rnd;
		pending_cmds.push_back(c);
		if (cmd <= CMD_STEP_END)
			queued++;
	endfunction

	// stream driver: inputs change on the falling edge
	always @(negedge clk) begin
		note_cmd_t c;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				send_gap <= $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				c = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= c.cmd;
				s_tdata <= {c.rnd, c.pitch};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n || hold_left != 0) begin
			m_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
			rx_gap <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin
		if (!hold_done && items_in == 400) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: predicts on input accept, checks on output accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			held_n = 0;
			step_pos = 0;
			pos_valid = 1'b0;
			cur_pitch = '0;
			sounding = 1'b0;
			arp_style = STYLE_UP;
			out_en = 1'b1;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				n_reg_writes++;
				case (cfg_index)
					REG_STYLE: arp_style = cfg_data;
					REG_OUT_EN: out_en = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("event_res", 16'(m_tuser), 16'(want.ev));
					check_field("event_pitch", m_tdata[15:0], want.ev_pitch);
					check_field("playing", 16'(m_tdata[16]), 16'(want.playing));
					check_field("note_count", 16'(m_tdata[21:17]), 16'(want.count));
					check_field("pitch_was_held", 16'(m_tdata[22]), 16'(want.was_held));
					check_field("overflow", 16'(m_tdata[23]), 16'(want.ovf));
					if (want.ev == EV_ON)
						n_on_ev++;
					if (want.ev == EV_OFF)
						n_off_ev++;
				end
				n_results++;
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_note_cmd(s_tuser, s_tdata[15:0],
					s_tdata[31:16]));
				items_in <= items_in + 1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else if (pending_cmds.size() != 0 || s_tvalid || cfg_valid
					|| expected_results.size() != 0)
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle;
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int n_items);
		logic [15:0] pool [$];
		int target;
		int psize;
		int r;
		psize = $urandom_range(3, 40);
		for (int j = 0; j < psize; j++)
			pool.push_back(16'($urandom));
		if ($urandom_range(0, 3) == 0) begin
			pool.push_back(16'h7fff);
			pool.push_back(16'h8000);
		end
		target = queued + n_items;
		while (queued < target) begin
			if ($urandom_range(0, 9) < 8) begin
				// chord build, then a run of steps with edits in between
				repeat ($urandom_range(1, 20))
					queue_cmd(CMD_NOTE_ON, pool[$urandom_range(0, pool.size() - 1)],
						16'($urandom));
				repeat ($urandom_range(2, 14)) begin
					queue_cmd(CMD_STEP_BEGIN, 16'($urandom), 16'($urandom));
					r = $urandom_range(0, 7);
					if (r == 0)
						queue_cmd(CMD_NOTE_OFF, pool[$urandom_range(0, pool.size() - 1)],
							16'($urandom));
					if (r == 1)
						queue_cmd(CMD_NOTE_ON, pool[$urandom_range(0, pool.size() - 1)],
							16'($urandom));
					if (r != 2)
						queue_cmd(CMD_STEP_END, 16'($urandom), 16'($urandom));
				end
				r = $urandom_range(0, 2);
				if (r == 0)
					queue_cmd(CMD_ALL_OFF, 16'($urandom), 16'($urandom));
				else if (r == 1)
					repeat ($urandom_range(1, 8))
						queue_cmd(CMD_NOTE_OFF, pool[$urandom_range(0, pool.size() - 1)],
							16'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					queue_cmd(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		logic [1:0] style_plan [PHASES];
		logic       en_plan [PHASES];
		int         idle_plan [PHASES];
		style_plan = '{STYLE_UP, STYLE_DOWN, STYLE_RANDOM, 2'd3, STYLE_RANDOM, STYLE_DOWN,
			STYLE_UP, STYLE_RANDOM, STYLE_DOWN};
		en_plan = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		idle_plan = '{10, 25, 0, 10, 40, 5, 15, 20, 0};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_STYLE, STYLE_UP);
		write_reg(REG_OUT_EN, 2'd1);
		idle_pct = 10;
		// step on an empty set, step end with nothing sounding
		queue_cmd(CMD_STEP_BEGIN, 16'h0000, 16'h0000);
		queue_cmd(CMD_STEP_END, 16'h0000, 16'hffff);
		queue_cmd(CMD_NOTE_ON, 16'h7fff, 16'h0000);
		queue_cmd(CMD_NOTE_ON, 16'h8000, 16'hffff);
		queue_cmd(CMD_NOTE_ON, 16'h0000, 16'h0000);
		queue_cmd(CMD_NOTE_ON, 16'h0005, 16'h0000);
		queue_cmd(CMD_NOTE_ON, 16'h0005, 16'h0000);     // duplicate
		queue_cmd(CMD_NOTE_OFF, 16'h0007, 16'h0000);    // not held
		queue_cmd(CMD_STEP_BEGIN, 16'h0000, 16'h0000);  // no position yet
		queue_cmd(CMD_STEP_END, 16'h0000, 16'h0000);
		queue_cmd(CMD_STEP_BEGIN, 16'h0000, 16'h0000);
		queue_cmd(CMD_NOTE_OFF, 16'h0000, 16'h0000);
		queue_cmd(CMD_STEP_BEGIN, 16'hffff, 16'hffff);
		queue_cmd(CMD_STEP_END, 16'h0000, 16'h0000);
		queue_cmd(3'd5, 16'hffff, 16'hffff);
		queue_cmd(3'd6, 16'h8000, 16'h0000);
		queue_cmd(3'd7, 16'h7fff, 16'hffff);
		queue_cmd(CMD_STEP_BEGIN, 16'h0000, 16'h0000);
		queue_cmd(CMD_NOTE_OFF, 16'h8000, 16'h0000);
		queue_cmd(CMD_NOTE_OFF, 16'h0005, 16'h0000);
		queue_cmd(CMD_NOTE_OFF, 16'h7fff, 16'h0000);    // set now empty
		queue_cmd(CMD_STEP_END, 16'h0000, 16'h0000);    // still ends the sounding note
		queue_cmd(CMD_ALL_OFF, 16'h0000, 16'h0000);
		queue_cmd(CMD_NOTE_ON, 16'h0001, 16'h0000);
		queue_cmd(CMD_ALL_OFF, 16'hffff, 16'hffff);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_STYLE, style_plan[ph]);
			write_reg(REG_OUT_EN, {1'b0, en_plan[ph]});
			idle_pct = idle_plan[ph];
			calm = (ph == PHASES - 1);
			random_phase(200);
			wait_idle();
		end

		repeat (50) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Ran %0d items to %0d results: %0d note-on and %0d note-off events,",
			items_in, n_results, n_on_ev, n_off_ev);
		$display("%0d inserts dropped on a full set, %0d register writes, %0d mismatches",
			n_dropped, n_reg_writes, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/arp_pkg.sv
hdl/arpeggiator_note_sequencer.sv
hdl/arp_checker.sv
bench/testbench.sv
